[src/bezier_subdivision_unit_assert.svh]
// Assertion macros used by the checker of the subdivision unit.
`ifndef BEZIER_SUBDIVISION_UNIT_ASSERT_SVH
`define BEZIER_SUBDIVISION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bsu_pkg.sv]
`default_nettype none
package bsu_pkg;

   localparam int MAX_DEGREE = 15;
   localparam int NUM_CELLS  = MAX_DEGREE + 1;
   localparam int IDX_W      = 4;
   localparam int EMIT_W     = 5;
   localparam int COORD_W    = 32;
   localparam int PARAM_W    = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PARAM_W-1:0] ONE_Q16       = 17'd65536;
   localparam logic [IDX_W-1:0]   DEGREE_RESET  = 4'd3;
   localparam logic               REG_CURVE_DEG = 1'b0;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic load;
      logic update;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_COMPUTE,
      ST_EMIT
   } state_type;

   // ((1-t)*a + t*b) rounded, written as a*2^16 + t*(b-a) so one multiplier suffices.
   function automatic logic signed [COORD_W-1:0] blend_coord(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic [PARAM_W-1:0]        t
   );
      logic signed [COORD_W:0]   diff;
      logic signed [51:0]        prod;
      logic signed [51:0]        sum;
      diff = 33'(signed'(b)) - 33'(signed'(a));
      prod = 52'(signed'({1'b0, t}) * diff);
      sum  = (52'(a) <<< 16) + prod + 52'sd32768;
      return sum[47:16];
   endfunction

   function automatic point_type blend_point(
      input point_type          a,
      input point_type          b,
      input logic [PARAM_W-1:0] t
   );
      point_type r;
      r.x = blend_coord(a.x, b.x, t);
      r.y = blend_coord(a.y, b.y, t);
      r.z = blend_coord(a.z, b.z, t);
      return r;
   endfunction

endpackage
`default_nettype wire

[src/bsu_cell.sv]
`default_nettype none
module bsu_cell (
   input  wire logic                          clock,
   input  wire bsu_pkg::cell_ctrl_type        ctrl,
   input  wire logic [bsu_pkg::PARAM_W-1:0]   param,
   input  wire bsu_pkg::point_type            load_pt,
   input  wire bsu_pkg::point_type            nbr_pt,
   output bsu_pkg::point_type                 pt,
   output bsu_pkg::point_type                 mix_pt
);

   bsu_pkg::point_type pt_ff;
   bsu_pkg::point_type pt_in;

   assign mix_pt = bsu_pkg::blend_point(pt_ff, nbr_pt, param);
   assign pt     = pt_ff;

   always_comb begin
      pt_in = pt_ff;
      if (ctrl.load) begin
         pt_in = load_pt;
      end else if (ctrl.update) begin
         pt_in = mix_pt;
      end else if (ctrl.shift) begin
         pt_in = nbr_pt;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

endmodule
`default_nettype wire

[src/bezier_subdivision_unit.sv]
`default_nettype none
// Splits a three-dimensional Bezier curve at a parameter t by de Casteljau. A set of
// curve_degree+1 control points is taken one request per cycle; t comes from the first
// point. After the last point the row of cells runs one de Casteljau level per cycle,
// each cell still in the level blending with its right neighbor. A set of degree n yields
// 2n+2 results, one per cycle while the result side does not stall. Requests are held off
// from the last point until the final result has been placed in the output register.
module bezier_subdivision_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [31:0]               req_coord_x,
   input  wire logic signed [31:0]               req_coord_y,
   input  wire logic signed [31:0]               req_coord_z,
   input  wire logic [16:0]                      req_split_param,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_which_half,
   output logic [3:0]                            rsp_point_index,
   output logic signed [31:0]                    rsp_out_x,
   output logic signed [31:0]                    rsp_out_y,
   output logic signed [31:0]                    rsp_out_z,
   output logic                                  rsp_is_curve_point,
   output logic                                  rsp_last_of_run,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [bsu_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bsu_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bsu_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int N = bsu_pkg::NUM_CELLS;

   bsu_pkg::state_type                  state_ff, state_in;
   logic [bsu_pkg::IDX_W-1:0]           load_count_ff, load_count_in;
   logic [bsu_pkg::PARAM_W-1:0]         param_ff, param_in;
   logic [bsu_pkg::IDX_W-1:0]           degree_ff;
   logic [bsu_pkg::IDX_W-1:0]           lvl_ff, lvl_in;
   logic [bsu_pkg::EMIT_W-1:0]          emit_ff, emit_in;
   bsu_pkg::point_type                  lcell_ff [N];
   bsu_pkg::point_type                  lcell_in [N];
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                half_ff, half_in;
   logic [bsu_pkg::IDX_W-1:0]           index_ff, index_in;
   bsu_pkg::point_type                  out_ff, out_in;
   logic                                curve_ff, curve_in;
   logic                                last_ff, last_in;

   bsu_pkg::cell_ctrl_type              ctrl [N];
   bsu_pkg::point_type                  cell_pt [N];
   bsu_pkg::point_type                  mix_pt [N];
   bsu_pkg::point_type                  req_pt;
   logic                                accept;
   logic                                out_load;
   logic                                csr_write;
   logic [bsu_pkg::EMIT_W-1:0]          deg_ext;
   logic [bsu_pkg::IDX_W-1:0]           right_idx;

   assign req_pt     = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
   assign req_stall  = (state_ff != bsu_pkg::ST_LOAD);
   assign accept     = req_valid && !req_stall;
   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign deg_ext    = {1'b0, degree_ff};
   assign right_idx  = bsu_pkg::IDX_W'(emit_ff - deg_ext - 5'd1);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == bsu_pkg::REG_CURVE_DEG) ?
                       {{(bsu_pkg::CSR_DATA_W-bsu_pkg::IDX_W){1'b0}}, degree_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= bsu_pkg::DEGREE_RESET;
      end else if (csr_write && csr_paddr[2] == bsu_pkg::REG_CURVE_DEG) begin
         degree_ff <= csr_pwdata[bsu_pkg::IDX_W-1:0];
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_cell
      bsu_pkg::point_type nbr;
      if (k == N - 1) begin : g_end
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_pt[k+1];
      end

      always_comb begin
         ctrl[k].load   = accept && (load_count_ff == bsu_pkg::IDX_W'(k));
         ctrl[k].update = (state_ff == bsu_pkg::ST_COMPUTE) && (lvl_ff <= degree_ff) &&
                          (5'(k) + {1'b0, lvl_ff} <= deg_ext);
         ctrl[k].shift  = (state_ff == bsu_pkg::ST_EMIT) && out_load &&
                          (emit_ff > deg_ext);
      end

      bsu_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl[k]),
         .param   (param_ff),
         .load_pt (req_pt),
         .nbr_pt  (nbr),
         .pt      (cell_pt[k]),
         .mix_pt  (mix_pt[k])
      );
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      param_in      = param_ff;
      lvl_in        = lvl_ff;
      emit_in       = emit_ff;
      lcell_in      = lcell_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      half_in       = half_ff;
      index_in      = index_ff;
      out_in        = out_ff;
      curve_in      = curve_ff;
      last_in       = last_ff;
      case (state_ff)
         bsu_pkg::ST_LOAD: begin
            if (accept) begin
               if (load_count_ff == '0) begin
                  param_in = (req_split_param > bsu_pkg::ONE_Q16) ?
                             bsu_pkg::ONE_Q16 : req_split_param;
               end
               if (load_count_ff >= degree_ff) begin
                  load_count_in = '0;
                  lvl_in        = bsu_pkg::IDX_W'(1);
                  state_in      = bsu_pkg::ST_COMPUTE;
               end else begin
                  load_count_in = load_count_ff + 4'd1;
               end
            end
         end
         bsu_pkg::ST_COMPUTE: begin
            // The first level cycle also saves the untouched first point as left point 0.
            if (lvl_ff == bsu_pkg::IDX_W'(1)) begin
               lcell_in[0] = cell_pt[0];
            end
            if (lvl_ff <= degree_ff) begin
               lcell_in[lvl_ff] = mix_pt[0];
            end
            if (lvl_ff >= degree_ff) begin
               emit_in  = '0;
               state_in = bsu_pkg::ST_EMIT;
            end else begin
               lvl_in = lvl_ff + 4'd1;
            end
         end
         bsu_pkg::ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               emit_in      = emit_ff + 5'd1;
               if (emit_ff <= deg_ext) begin
                  half_in  = 1'b0;
                  index_in = emit_ff[bsu_pkg::IDX_W-1:0];
                  out_in   = lcell_ff[0];
                  curve_in = (emit_ff == deg_ext);
                  last_in  = 1'b0;
                  for (int i = 0; i < N - 1; i++) begin
                     lcell_in[i] = lcell_ff[i+1];
                  end
               end else begin
                  half_in  = 1'b1;
                  index_in = right_idx;
                  out_in   = cell_pt[0];
                  curve_in = 1'b0;
                  last_in  = (right_idx == degree_ff);
                  if (right_idx == degree_ff) begin
                     state_in = bsu_pkg::ST_LOAD;
                  end
               end
            end
         end
         default: begin
            state_in = bsu_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bsu_pkg::ST_LOAD;
         load_count_ff <= '0;
         param_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         param_ff      <= param_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff   <= lvl_in;
      emit_ff  <= emit_in;
      lcell_ff <= lcell_in;
      half_ff  <= half_in;
      index_ff <= index_in;
      out_ff   <= out_in;
      curve_ff <= curve_in;
      last_ff  <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_which_half     = half_ff;
   assign rsp_point_index    = index_ff;
   assign rsp_out_x          = out_ff.x;
   assign rsp_out_y          = out_ff.y;
   assign rsp_out_z          = out_ff.z;
   assign rsp_is_curve_point = curve_ff;
   assign rsp_last_of_run    = last_ff;

endmodule
`default_nettype wire

[src/bsu_checker.sv]
`default_nettype none
`include "bezier_subdivision_unit_assert.svh"
module bsu_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic                             rsp_which_half,
   input wire logic [3:0]                       rsp_point_index,
   input wire logic signed [31:0]               rsp_out_x,
   input wire logic signed [31:0]               rsp_out_y,
   input wire logic signed [31:0]               rsp_out_z,
   input wire logic                             rsp_is_curve_point,
   input wire logic                             rsp_last_of_run
);

   `BSU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_point_index), "stalled result changed")
   `BSU_ASSERT_SAME(a_left_busy, rsp_valid && !rsp_which_half, req_stall, "request taken while right half is still owed")
   `BSU_ASSERT_SAME(a_curve_left, rsp_valid && rsp_is_curve_point, !rsp_which_half && !rsp_last_of_run, "curve point flagged outside the left half")
   `BSU_ASSERT_SAME(a_last_right, rsp_valid && rsp_last_of_run, rsp_which_half, "end of run flagged on a left point")

endmodule

bind bezier_subdivision_unit bsu_checker u_bsu_checker (.*);
`default_nettype wire

[tb/bezier_subdivision_unit_tb.sv]
`default_nettype none
module bezier_subdivision_unit_tb;

   localparam int CYCLE_LIMIT = 800000;
   localparam int SETTLE_CYCLES = 48;

   typedef struct {
      logic        which_half;
      logic [3:0]  point_index;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        is_curve;
      logic        last_of_run;
   } split_point_type;

   typedef struct {
      int          new_degree;   // -1 leaves the register alone
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [16:0] t;
      bit          typed;        // a degree-zero point is echoed unchanged
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic signed [31:0] req_coord_z = '0;
   logic [16:0] req_split_param = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_which_half;
   logic [3:0] rsp_point_index;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_is_curve_point, rsp_last_of_run;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [bsu_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [bsu_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [bsu_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bezier_subdivision_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model state of the subdivider.
   logic [31:0] ctl_x [bsu_pkg::NUM_CELLS];
   logic [31:0] ctl_y [bsu_pkg::NUM_CELLS];
   logic [31:0] ctl_z [bsu_pkg::NUM_CELLS];
   int unsigned points_loaded = 0;
   logic [16:0] split_t = '0;
   logic [3:0]  degree = bsu_pkg::DEGREE_RESET;

   split_point_type pending_points[$];
   stim_row_type    directed_rows[$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int unsigned cycles = 0;

   function automatic logic [31:0] lerp_coord(logic [31:0] a, logic [31:0] b, logic [16:0] t);
      longint sa, sb, s;
      sa = longint'(signed'(a));
      sb = longint'(signed'(b));
      s = (longint'(65536) - longint'(t)) * sa + longint'(t) * sb + 64'sd32768;
      return 32'(s >>> 16);
   endfunction

   function automatic void push_point(logic half, int idx, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic curve, logic last);
      split_point_type p;
      p.which_half = half;
      p.point_index = 4'(idx);
      p.x = x;
      p.y = y;
      p.z = z;
      p.is_curve = curve;
      p.last_of_run = last;
      pending_points.insert(pending_points.size(), p);
   endfunction

   // Loads one control point and, when the set is complete, queues both halves unless quiet is set.
   function automatic void load_and_split(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic [16:0] t, bit quiet);
      int unsigned n, slot;
      logic [31:0] lx [bsu_pkg::NUM_CELLS];
      logic [31:0] ly [bsu_pkg::NUM_CELLS];
      logic [31:0] lz [bsu_pkg::NUM_CELLS];
      n = degree;
      slot = points_loaded > bsu_pkg::MAX_DEGREE ? bsu_pkg::MAX_DEGREE : points_loaded;
      if (slot == 0) split_t = t > bsu_pkg::ONE_Q16 ? bsu_pkg::ONE_Q16 : t;
      ctl_x[slot] = x;
      ctl_y[slot] = y;
      ctl_z[slot] = z;
      points_loaded = slot + 1;
      if (points_loaded < n + 1) return;
      points_loaded = 0;
      lx[0] = ctl_x[0];
      ly[0] = ctl_y[0];
      lz[0] = ctl_z[0];
      for (int j = 1; j <= n; j++) begin
         for (int k = 0; k + j <= n; k++) begin
            ctl_x[k] = lerp_coord(ctl_x[k], ctl_x[k+1], split_t);
            ctl_y[k] = lerp_coord(ctl_y[k], ctl_y[k+1], split_t);
            ctl_z[k] = lerp_coord(ctl_z[k], ctl_z[k+1], split_t);
         end
         lx[j] = ctl_x[0];
         ly[j] = ctl_y[0];
         lz[j] = ctl_z[0];
      end
      if (quiet) return;
      for (int k = 0; k <= n; k++) push_point(1'b0, k, lx[k], ly[k], lz[k], k == n, 1'b0);
      for (int k = 0; k <= n; k++)
         push_point(1'b1, k, ctl_x[k], ctl_y[k], ctl_z[k], 1'b0, k == n);
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0h expected %0h at cycle %0d", field, got, want, cycles);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("bezier_subdivision_unit verification failed");
         $finish;
      end
   end

   // Result side: check every accepted point, then pick the stall for the next cycle.
   always @(posedge clock) begin
      split_point_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_points.size() == 0) begin
               report_mismatch("unexpected result", rsp_point_index, 0);
            end else begin
               w = pending_points.pop_front();
               if (rsp_which_half !== w.which_half)
                  report_mismatch("which_half", rsp_which_half, w.which_half);
               if (rsp_point_index !== w.point_index)
                  report_mismatch("point_index", rsp_point_index, w.point_index);
               if (rsp_out_x !== w.x) report_mismatch("out_x", rsp_out_x, w.x);
               if (rsp_out_y !== w.y) report_mismatch("out_y", rsp_out_y, w.y);
               if (rsp_out_z !== w.z) report_mismatch("out_z", rsp_out_z, w.z);
               if (rsp_is_curve_point !== w.is_curve)
                  report_mismatch("is_curve_point", rsp_is_curve_point, w.is_curve);
               if (rsp_last_of_run !== w.last_of_run)
                  report_mismatch("last_of_run", rsp_last_of_run, w.last_of_run);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Called at a rising edge; returns at the edge where the request was taken.
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [16:0] t,
                             bit quiet);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      req_split_param <= t;
      do @(posedge clock); while (req_stall);
      load_and_split(x, y, z, t, quiet);
   endtask

   // Holds requests off until every queued point has come back and the block is quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_degree(int value);
      drain_results();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= bsu_pkg::CSR_ADDR_W'(4 * bsu_pkg::REG_CURVE_DEG);
      csr_pwdata <= bsu_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      degree = 4'(value);
   endtask

   function automatic void add_row(int deg, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [16:0] t, bit typed);
      stim_row_type r;
      r.new_degree = deg;
      r.x = x;
      r.y = y;
      r.z = z;
      r.t = t;
      r.typed = typed;
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0: return $urandom_range(1, 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'($signed($urandom_range(2097151)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] pick_param();
      int r;
      r = $urandom_range(99);
      if (r < 10) return $urandom_range(1, 0) ? bsu_pkg::ONE_Q16 : 17'd0;
      if (r < 25) return 17'($urandom_range(131071));
      return 17'($urandom_range(65536));
   endfunction

   initial begin
      int sent;
      stim_row_type r;
      // Reset degree: extreme coordinates at t of zero, one, and above one.
      add_row(-1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 17'd0, 0);
      add_row(-1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd0, 0);
      add_row(-1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 17'd0, 0);
      add_row(-1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 17'd0, 0);
      add_row(-1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, bsu_pkg::ONE_Q16, 0);
      add_row(-1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 17'd0, 0);
      add_row(-1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 17'd0, 0);
      add_row(-1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hEDCB_A988, 17'd0, 0);
      add_row(-1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF, 0);
      add_row(-1, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 17'd0, 0);
      add_row(-1, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 17'd0, 0);
      add_row(-1, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0001, 17'd0, 0);
      // Degree zero: a single point comes straight back as both halves.
      add_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'h1FFFF, 1);
      add_row(-1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 17'd0, 1);
      // A degree lowered mid-set completes the set on the following point.
      add_row(3, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 17'h08000, 0);
      add_row(-1, 32'h0004_0000, 32'hFFFB_0000, 32'h0006_0000, 17'd0, 0);
      add_row(-1, 32'hFFF9_0000, 32'h0008_0000, 32'h0009_0000, 17'd0, 0);
      add_row(1, 32'h000A_0000, 32'h000B_0000, 32'hFFF4_0000, 17'd0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.new_degree >= 0) write_degree(r.new_degree);
         send_point(r.x, r.y, r.z, r.t, r.typed);
         if (r.typed) begin
            push_point(1'b0, 0, r.x, r.y, r.z, 1'b1, 1'b0);
            push_point(1'b1, 0, r.x, r.y, r.z, 1'b0, 1'b1);
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         send_idle = mode == 0 ? 17 : (mode == 1 ? 81 : 0);
         recv_idle = mode == 0 ? 81 : (mode == 1 ? 17 : 0);
         write_degree(mode == 1 ? 15 : $urandom_range(1, 6));
         sent = 0;
         while (sent < 84) begin
            if (points_loaded == 0 && $urandom_range(3) == 0) begin
               case ($urandom_range(9))
                  0: write_degree(15);
                  1, 2: write_degree(0);
                  3, 4: write_degree(1);
                  default: write_degree($urandom_range(2, 7));
               endcase
            end else if (points_loaded != 0 && $urandom_range(29) == 0) begin
               write_degree($urandom_range(15));
            end
            send_point(pick_coord(), pick_coord(), pick_coord(), pick_param(), 0);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("bezier_subdivision_unit verification clean");
      end else begin
         $display("bezier_subdivision_unit verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
